/* rtl/core/mbe_pkg.sv */
// ============================================================================
// mbe_pkg : shared types and constants for the escape-time engine
// Configuration layout, register indexes and the queue word between the
// front and back ends.
// ============================================================================
package mbe_pkg;

    localparam int CoordW   = 32;           // Q3.28 coordinate
    localparam int StepW    = 31;           // unsigned Q3.28 step
    localparam int FracBits = 28;
    localparam int PixW     = 10;
    localparam int CountW   = 16;
    localparam int IdxW     = 3;
    localparam int DataW    = 32;
    localparam int ProdW    = 2 * CoordW;

    // |z|^2 > 4.0 in Q7.56
    localparam logic [ProdW-1:0] EscLimit = ProdW'(64'd4) << (2 * FracBits);

    typedef enum logic [IdxW-1:0] {
        REG_X_START         = 3'd0,
        REG_Y_START         = 3'd1,
        REG_X_STEP          = 3'd2,
        REG_Y_STEP          = 3'd3,
        REG_ITERATION_LIMIT = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [CoordW-1:0] x_start;
        logic [CoordW-1:0] y_start;
        logic [StepW-1:0]  x_step;
        logic [StepW-1:0]  y_step;
        logic [CountW-1:0] iteration_limit;
    } cfg_t;

    localparam logic [CoordW-1:0] XStartRst = 32'hE000_0000;
    localparam logic [CoordW-1:0] YStartRst = 32'hF000_0000;
    localparam logic [StepW-1:0]  XStepRst  = 31'd786432;
    localparam logic [StepW-1:0]  YStepRst  = 31'd524288;
    localparam logic [CountW-1:0] LimitRst  = 16'd1580;

    // one mapped pixel waiting for the iteration unit
    typedef struct packed {
        logic [PixW-1:0]          col;
        logic [PixW-1:0]          row;
        logic signed [CoordW-1:0] cr;
        logic signed [CoordW-1:0] ci;
    } point_t;

endpackage

/* rtl/core/mbe_if.sv */
// ============================================================================
// mbe_if : pixel and result channels
// valid/ready channels; a word moves when both are high at a clock edge.
// ============================================================================
interface mbe_pix_if;
    logic                      valid;
    logic                      ready;
    logic [mbe_pkg::PixW-1:0]  pixel_col;
    logic [mbe_pkg::PixW-1:0]  pixel_row;

    modport source (output valid, output pixel_col, output pixel_row, input ready);
    modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface mbe_res_if;
    logic                       valid;
    logic                       ready;
    logic [mbe_pkg::PixW-1:0]   out_col;
    logic [mbe_pkg::PixW-1:0]   out_row;
    logic [mbe_pkg::CountW-1:0] iteration_count;
    logic                       escaped;

    modport source (output valid, output out_col, output out_row,
                    output iteration_count, output escaped, input ready);
    modport sink   (input valid, input out_col, input out_row,
                    input iteration_count, input escaped, output ready);
endinterface

/* rtl/core/mbe_front.sv */
// ============================================================================
// mbe_front : pixel to complex-plane mapping
// Two stages: (index+1)*step product, then add of the start coordinate.
// ============================================================================
module mbe_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  mbe_pkg::cfg_t      cfg,
    mbe_pix_if.sink            pixel,
    output logic               q_valid,
    input  logic               q_ready,
    output mbe_pkg::point_t    q_word
);

    logic                          s1_valid_reg, s1_valid_next;
    logic                          s2_valid_reg, s2_valid_next;
    logic [mbe_pkg::PixW-1:0]      col1_reg, row1_reg;
    logic [mbe_pkg::CoordW-1:0]    xoff1_reg, yoff1_reg;
    mbe_pkg::point_t               s2_reg;

    logic                          s1_free, s2_free;
    logic [mbe_pkg::PixW:0]        col_inc, row_inc;
    logic [mbe_pkg::PixW+mbe_pkg::StepW-1:0] xprod, yprod;

    assign s2_free     = !s2_valid_reg || q_ready;
    assign s1_free     = !s1_valid_reg || s2_free;
    assign pixel.ready = s1_free;

    assign col_inc = {1'b0, pixel.pixel_col} + (mbe_pkg::PixW+1)'(1);
    assign row_inc = {1'b0, pixel.pixel_row} + (mbe_pkg::PixW+1)'(1);
    assign xprod   = (mbe_pkg::PixW+mbe_pkg::StepW)'(col_inc)
                   * (mbe_pkg::PixW+mbe_pkg::StepW)'(cfg.x_step);
    assign yprod   = (mbe_pkg::PixW+mbe_pkg::StepW)'(row_inc)
                   * (mbe_pkg::PixW+mbe_pkg::StepW)'(cfg.y_step);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        if (s1_free)
        begin
            s1_valid_next = pixel.valid;
        end
        if (s2_free)
        begin
            s2_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // offsets wrap modulo 2^32 like the coordinate sum
    always_ff @(posedge clk)
    begin
        if (s1_free && pixel.valid)
        begin
            col1_reg  <= pixel.pixel_col;
            row1_reg  <= pixel.pixel_row;
            xoff1_reg <= xprod[mbe_pkg::CoordW-1:0];
            yoff1_reg <= yprod[mbe_pkg::CoordW-1:0];
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_reg.col <= col1_reg;
            s2_reg.row <= row1_reg;
            s2_reg.cr  <= cfg.x_start + xoff1_reg;
            s2_reg.ci  <= cfg.y_start + yoff1_reg;
        end
    end

    assign q_valid = s2_valid_reg;
    assign q_word  = s2_reg;

endmodule

/* rtl/core/mbe_queue.sv */
// ============================================================================
// mbe_queue : two-entry queue between front and back ends
// ============================================================================
module mbe_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  mbe_pkg::point_t in_word,
    output logic            out_valid,
    input  logic            out_ready,
    output mbe_pkg::point_t out_word
);

    mbe_pkg::point_t  mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_word  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_word;
        end
    end

endmodule

/* rtl/core/mbe_core.sv */
// ============================================================================
// mbe_core : z = z*z + c iteration unit
// Each iteration: products, then escape test and update.
// ============================================================================
module mbe_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [mbe_pkg::CountW-1:0] iteration_limit,
    input  logic            q_valid,
    output logic            q_ready,
    input  mbe_pkg::point_t q_word,
    mbe_res_if.source       result
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_CHK  = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic                            res_valid_reg, res_valid_next;
    logic [mbe_pkg::CountW-1:0]      n_reg;
    logic [mbe_pkg::PixW-1:0]        col_reg, row_reg;
    logic signed [mbe_pkg::CoordW-1:0] zr_reg, zi_reg, cr_reg, ci_reg;
    logic signed [mbe_pkg::ProdW-1:0]  rr_reg, ii_reg, ri_reg;
    logic [mbe_pkg::PixW-1:0]        out_col_reg, out_row_reg;
    logic [mbe_pkg::CountW-1:0]      out_count_reg;
    logic                            out_esc_reg;

    logic                            out_free, at_limit, done, load;
    logic [mbe_pkg::ProdW-1:0]       mag, diff;

    assign out_free = !res_valid_reg || result.ready;
    assign mag      = rr_reg + ii_reg;
    assign diff     = rr_reg - ii_reg;
    assign at_limit = (n_reg >= iteration_limit);
    assign done     = at_limit || (mag > mbe_pkg::EscLimit);
    assign q_ready  = (state_reg == ST_IDLE);
    assign load     = q_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (!done)
                begin
                    state_next = ST_MUL;
                end
                else if (out_free)
                begin
                    state_next     = ST_IDLE;
                    res_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // datapath; narrowing keeps floor semantics by taking bit slices
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            col_reg <= q_word.col;
            row_reg <= q_word.row;
            cr_reg  <= q_word.cr;
            ci_reg  <= q_word.ci;
            zr_reg  <= q_word.cr;
            zi_reg  <= q_word.ci;
            n_reg   <= '0;
        end
        if (state_reg == ST_MUL)
        begin
            rr_reg <= zr_reg * zr_reg;
            ii_reg <= zi_reg * zi_reg;
            ri_reg <= zr_reg * zi_reg;
        end
        if (state_reg == ST_CHK)
        begin
            if (!done)
            begin
                zr_reg <= diff[mbe_pkg::FracBits +: mbe_pkg::CoordW] + cr_reg;
                zi_reg <= ri_reg[mbe_pkg::FracBits-1 +: mbe_pkg::CoordW] + ci_reg;
                n_reg  <= n_reg + mbe_pkg::CountW'(1);
            end
            else if (out_free)
            begin
                out_col_reg   <= col_reg;
                out_row_reg   <= row_reg;
                out_count_reg <= n_reg;
                out_esc_reg   <= !at_limit;
            end
        end
    end

    assign result.valid           = res_valid_reg;
    assign result.out_col         = out_col_reg;
    assign result.out_row         = out_row_reg;
    assign result.iteration_count = out_count_reg;
    assign result.escaped         = out_esc_reg;

endmodule

/* rtl/core/mandelbrot_escape_time_top.sv */
// ============================================================================
// mandelbrot_escape_time_top : escape-time pixel engine
// Usage:
//  - pixel channel takes one word (column, row); the result channel gives one
//    word (column, row, iteration count, escaped flag) per pixel, in order.
//  - write port (wr_en, wr_index, wr_data) sets x_start, y_start, x_step,
//    y_step and iteration_limit; write only while the engine is idle.
//  - front end maps a pixel to c (product, then start add); a queue holds up to
//    two mapped pixels, so new words are taken while the back end iterates.
//  - back end runs each iteration as a multiply state, then an escape test
//    and update state, after a load in the idle state; a pixel finishes in
//    the test state once the output register is free; this loop sets the
//    throughput.
//  - a stalled result waits in the output register; the back end holds the
//    next finished pixel until that word is taken, and the queue then fills.
//  - reset empties the pipeline and loads the default view (-2.0, -1.0,
//    steps 786432 and 524288, limit 1580).
// ============================================================================
module mandelbrot_escape_time_top
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [mbe_pkg::IdxW-1:0]   wr_index,
    input  logic [mbe_pkg::DataW-1:0]  wr_data,
    mbe_pix_if.sink                    pixel,
    mbe_res_if.source                  result
);

    mbe_pkg::cfg_t   cfg_reg, cfg_next;
    mbe_pkg::point_t f_word, q_word;
    logic            f_valid, f_ready, q_valid, q_ready;

    // configuration registers; unknown indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (mbe_pkg::reg_index_t'(wr_index))
                mbe_pkg::REG_X_START:
                    cfg_next.x_start = wr_data;
                mbe_pkg::REG_Y_START:
                    cfg_next.y_start = wr_data;
                mbe_pkg::REG_X_STEP:
                    cfg_next.x_step = wr_data[mbe_pkg::StepW-1:0];
                mbe_pkg::REG_Y_STEP:
                    cfg_next.y_step = wr_data[mbe_pkg::StepW-1:0];
                mbe_pkg::REG_ITERATION_LIMIT:
                    cfg_next.iteration_limit = wr_data[mbe_pkg::CountW-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_start         <= mbe_pkg::XStartRst;
            cfg_reg.y_start         <= mbe_pkg::YStartRst;
            cfg_reg.x_step          <= mbe_pkg::XStepRst;
            cfg_reg.y_step          <= mbe_pkg::YStepRst;
            cfg_reg.iteration_limit <= mbe_pkg::LimitRst;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end: coordinate mapping
    mbe_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .pixel   (pixel),
        .q_valid (f_valid),
        .q_ready (f_ready),
        .q_word  (f_word)
    );

    // decoupling queue
    mbe_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_word   (f_word),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_word  (q_word)
    );

    // back end: iteration and result register
    mbe_core u_core
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .iteration_limit (cfg_reg.iteration_limit),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_word          (q_word),
        .result          (result)
    );

endmodule
